// ===== src/apm_pkg.sv =====
package apm_pkg;

  localparam int unsigned PRES_W  = 12;
  localparam int unsigned HOLD_W  = 11;
  localparam int unsigned DLY_W   = 13;
  localparam int unsigned GRAD_W  = 10;
  localparam int unsigned EST_W   = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CIDX_W  = 2;

  localparam logic [HOLD_W-1:0] P_MIN   = 11'd500;
  localparam logic [HOLD_W-1:0] P_MAX   = 11'd1500;
  localparam logic [DLY_W-1:0]  DLY_MAX = 13'd7650;
  localparam logic [GRAD_W-1:0] GRD_SAT = 10'd1000;

  // est*2/25 == (est * ceil(2^22/25)) >> 21, exact over the 16-bit input range
  localparam logic [17:0] REF_RECIP = 18'd167773;
  localparam int unsigned REF_SHIFT = 21;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_KEY_ON = 2'd1;
  localparam logic [1:0] REQ_INIT   = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_HIGH_THR   = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_LOW_TENS   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_GRAD_DELAY = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_GRAD_THR   = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [PRES_W-1:0] pressure;
    logic              engine_running;
    logic              inhibit_range;
    logic              inhibit_gradient;
    logic              inhibit_old;
    logic [EST_W-1:0]  estimated_ref;
  } in_item_t;

  typedef struct packed {
    logic              range_active;
    logic              fault_high;
    logic              fault_low;
    logic              gradient_active;
    logic              gradient_enable;
    logic              fault_gradient;
    logic [GRAD_W-1:0] gradient_value;
    logic [HOLD_W-1:0] latched_pressure;
    logic              old_check_active;
    logic [HOLD_W-1:0] ref_old_pressure;
    logic [HOLD_W-1:0] start_pressure;
    logic [DLY_W-1:0]  delay_count;
  } out_item_t;

  typedef struct packed {
    logic [11:0] high_threshold;
    logic [7:0]  low_threshold_tens;
    logic [15:0] grad_delay_ticks;
    logic [11:0] grad_threshold;
  } cfg_t;

  function automatic logic [HOLD_W-1:0] clamp_p(input logic [12:0] v);
    logic [HOLD_W-1:0] r;
    if (v < 13'(P_MIN)) begin
      r = P_MIN;
    end else if (v > 13'(P_MAX)) begin
      r = P_MAX;
    end else begin
      r = v[HOLD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/apm_if.sv =====
interface apm_in_if import apm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface apm_out_if import apm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/apm_cfg_regs.sv =====
module apm_cfg_regs import apm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  output cfg_t              cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_threshold     <= 12'd1100;
      cfg_q.low_threshold_tens <= 8'd50;
      cfg_q.grad_delay_ticks   <= 16'd100;
      cfg_q.grad_threshold     <= 12'd100;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HIGH_THR:   cfg_q.high_threshold     <= cfg_data_i[11:0];
        CFG_LOW_TENS:   cfg_q.low_threshold_tens <= cfg_data_i[7:0];
        CFG_GRAD_DELAY: cfg_q.grad_delay_ticks   <= cfg_data_i;
        CFG_GRAD_THR:   cfg_q.grad_threshold     <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/apm_ref_scale.sv =====
module apm_ref_scale import apm_pkg::*; (
  input  logic [EST_W-1:0]  est_i,
  output logic [HOLD_W-1:0] ref_o
);

  logic [33:0] prod;
  logic [12:0] quot;

  // reciprocal multiply stands in for the divide by 25
  assign prod = {18'd0, est_i} * {16'd0, REF_RECIP};
  assign quot = prod[REF_SHIFT +: 13];
  assign ref_o = clamp_p(quot);

endmodule

// ===== src/apm_engine.sv =====
module apm_engine import apm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t res_o
);

  logic [DLY_W-1:0]  dly_q, dly_d;
  logic              to_q, to_d;
  logic              sf_q, sf_d;
  logic              sfp_q, sfp_d;
  logic [HOLD_W-1:0] start_q, start_d;
  logic [PRES_W-1:0] held_q, held_d;
  logic              r_act_q, r_act_d;
  logic              r_hi_q, r_hi_d;
  logic              r_lo_q, r_lo_d;
  logic              g_act_q, g_act_d;
  logic              g_en_q, g_en_d;
  logic              g_flt_q, g_flt_d;
  logic [GRAD_W-1:0] ghold_q, ghold_d;
  logic [HOLD_W-1:0] lhold_q, lhold_d;
  logic [HOLD_W-1:0] refo_q, refo_d;
  logic              old_q, old_d;

  logic [HOLD_W-1:0] ref_scaled;
  logic [PRES_W-1:0] low_lim;
  logic [DLY_W-1:0]  dly_load;
  logic              g_run;
  logic              en;
  logic [PRES_W-1:0] held_n;
  logic [PRES_W-1:0] s1;
  logic [PRES_W-1:0] diff;

  apm_ref_scale u_ref_scale (
    .est_i (item_i.estimated_ref),
    .ref_o (ref_scaled)
  );

  assign low_lim  = {1'b0, cfg_i.low_threshold_tens, 3'b000}
                  + {3'b000, cfg_i.low_threshold_tens, 1'b0};
  assign dly_load = (cfg_i.grad_delay_ticks > 16'(DLY_MAX)) ? DLY_MAX
                                                            : cfg_i.grad_delay_ticks[DLY_W-1:0];
  assign g_run    = !item_i.inhibit_gradient && item_i.engine_running;

  always_comb begin
    dly_d   = dly_q;
    to_d    = to_q;
    sf_d    = sf_q;
    sfp_d   = sfp_q;
    start_d = start_q;
    held_d  = held_q;
    r_act_d = r_act_q;
    r_hi_d  = r_hi_q;
    r_lo_d  = r_lo_q;
    g_act_d = g_act_q;
    g_en_d  = g_en_q;
    g_flt_d = g_flt_q;
    ghold_d = ghold_q;
    lhold_d = lhold_q;
    refo_d  = refo_q;
    old_d   = old_q;
    en      = 1'b0;
    held_n  = held_q;
    s1      = '0;
    diff    = '0;

    case (item_i.req_type)
      REQ_TICK: begin
        if (!item_i.inhibit_range) begin
          r_act_d = 1'b1;
          r_hi_d  = item_i.pressure > cfg_i.high_threshold;
          r_lo_d  = item_i.pressure < low_lim;
        end else begin
          r_act_d = 1'b0;
        end

        // delay timer loads on the first tick after a key-on store
        if (!sfp_q && sf_q) begin
          dly_d = dly_load;
          to_d  = (dly_load == '0);
        end else if (dly_q != '0) begin
          dly_d = dly_q - 1'b1;
          to_d  = (dly_q == DLY_W'(1));
        end
        en    = !to_q && to_d && sf_q;
        sfp_d = sf_q;

        g_act_d = g_run;
        g_en_d  = en;

        if (g_run) begin
          if (en) begin
            s1     = {1'b0, start_q};
            held_n = item_i.pressure;
          end else if (!sf_q) begin
            held_n = '0;
          end
          diff    = (s1 >= held_n) ? s1 - held_n : held_n - s1;
          held_d  = held_n;
          g_flt_d = diff > cfg_i.grad_threshold;
          ghold_d = (diff < PRES_W'(GRD_SAT)) ? diff[GRAD_W-1:0] : GRD_SAT;
          lhold_d = clamp_p({1'b0, held_n});
        end

        old_d = !item_i.inhibit_old && item_i.engine_running;
      end
      REQ_KEY_ON: begin
        start_d = clamp_p({1'b0, item_i.pressure});
        sf_d    = 1'b1;
      end
      REQ_INIT: begin
        r_act_d = 1'b0;
        r_hi_d  = 1'b0;
        r_lo_d  = 1'b0;
        g_act_d = 1'b0;
        g_flt_d = 1'b0;
        old_d   = 1'b0;
        start_d = P_MIN;
        refo_d  = ref_scaled;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_q   <= '0;
      to_q    <= 1'b0;
      sf_q    <= 1'b0;
      sfp_q   <= 1'b0;
      start_q <= P_MIN;
      held_q  <= '0;
      r_act_q <= 1'b0;
      r_hi_q  <= 1'b0;
      r_lo_q  <= 1'b0;
      g_act_q <= 1'b0;
      g_en_q  <= 1'b0;
      g_flt_q <= 1'b0;
      ghold_q <= '0;
      lhold_q <= P_MIN;
      refo_q  <= P_MIN;
      old_q   <= 1'b0;
    end else if (step_i) begin
      dly_q   <= dly_d;
      to_q    <= to_d;
      sf_q    <= sf_d;
      sfp_q   <= sfp_d;
      start_q <= start_d;
      held_q  <= held_d;
      r_act_q <= r_act_d;
      r_hi_q  <= r_hi_d;
      r_lo_q  <= r_lo_d;
      g_act_q <= g_act_d;
      g_en_q  <= g_en_d;
      g_flt_q <= g_flt_d;
      ghold_q <= ghold_d;
      lhold_q <= lhold_d;
      refo_q  <= refo_d;
      old_q   <= old_d;
    end
  end

  always_comb begin
    res_o.range_active     = r_act_q;
    res_o.fault_high       = r_hi_q;
    res_o.fault_low        = r_lo_q;
    res_o.gradient_active  = g_act_q;
    res_o.gradient_enable  = g_en_q;
    res_o.fault_gradient   = g_flt_q;
    res_o.gradient_value   = ghold_q;
    res_o.latched_pressure = lhold_q;
    res_o.old_check_active = old_q;
    res_o.ref_old_pressure = refo_q;
    res_o.start_pressure   = start_q;
    res_o.delay_count      = dly_q;
  end

endmodule

// ===== src/ambient_pressure_plausibility_monitor.sv =====
// Ambient pressure plausibility monitor. Takes one request (tick, key-on store or init;
// an unused code leaves the state as it is) per clock while the output side is ready,
// and returns one status transfer per request. Requests land in an input register;
// the state and flag registers then update in a single pass and double as the output
// register, so with a ready output the sustained rate is one item per cycle, set by
// that single update step. A stalled output holds the input register, and the input
// side stalls only once both are full. Configuration writes are applied on the next edge
// and must only be issued while no request is in flight.
module ambient_pressure_plausibility_monitor import apm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  apm_in_if.sink            in_i,
  apm_out_if.source         out_o
);

  cfg_t     cfg;
  in_item_t in_q;
  logic     in_vq;
  logic     out_vq;
  logic     adv;

  apm_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // item leaves the input register when the result slot is free or being drained
  assign adv        = in_vq && (!out_vq || out_o.ready);
  assign in_i.ready = !in_vq || adv;

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq  <= 1'b0;
      out_vq <= 1'b0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        in_vq <= 1'b1;
      end else if (adv) begin
        in_vq <= 1'b0;
      end
      if (adv) begin
        out_vq <= 1'b1;
      end else if (out_o.ready) begin
        out_vq <= 1'b0;
      end
    end
  end

  apm_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (out_o.data)
  );

  assign out_o.valid = out_vq;

endmodule

// ===== bench/tb_ambient_pressure_plausibility_monitor.sv =====
module tb_ambient_pressure_plausibility_monitor;
  timeunit 1ns;
  timeprecision 1ps;
  import apm_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned IDLE_PCT = 35;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CIDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;
  bit quiet = 1'b0;
  int unsigned mismatches = 0;

  apm_in_if in_if ();
  apm_out_if out_if ();

  ambient_pressure_plausibility_monitor dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // monitor settings as the block should see them
  logic [11:0] thr_high = 12'd1100;
  logic [7:0] thr_low_tens = 8'd50;
  logic [15:0] delay_set = 16'd100;
  logic [11:0] thr_grad = 12'd100;

  // monitor state
  logic [DLY_W-1:0] delay_ctr = '0;
  bit timeout_seen = 1'b0;
  bit keyon_seen = 1'b0;
  bit keyon_seen_q = 1'b0;
  logic [HOLD_W-1:0] start_p = P_MIN;
  logic [PRES_W-1:0] held_p = '0;
  bit r_act = 1'b0, r_hi = 1'b0, r_lo = 1'b0;
  bit g_act = 1'b0, g_en = 1'b0, g_flt = 1'b0;
  logic [GRAD_W-1:0] grad_held = '0;
  logic [HOLD_W-1:0] lat_held = P_MIN;
  logic [HOLD_W-1:0] ref_old = P_MIN;
  bit old_en = 1'b0;

  out_item_t pending_status[$];
  dir_row_t dir_rows[$];

  function automatic logic [HOLD_W-1:0] clip_pressure(int unsigned v);
    if (v < P_MIN) return P_MIN;
    if (v > P_MAX) return P_MAX;
    return HOLD_W'(v);
  endfunction

  function automatic out_item_t predict_status(in_item_t it);
    out_item_t s;
    int unsigned p, diff, src_side;
    bit was_timed, pulse, g_run;
    p = it.pressure;
    case (it.req_type)
      REQ_TICK: begin
        was_timed = timeout_seen;
        g_run = !it.inhibit_gradient && it.engine_running;
        if (!it.inhibit_range) begin
          r_act = 1'b1;
          r_hi = p > thr_high;
          r_lo = p < int'(thr_low_tens) * 10;
        end else begin
          r_act = 1'b0;
        end
        // timer loads once, on the first tick after the key-on store
        if (!keyon_seen_q && keyon_seen) begin
          delay_ctr = (delay_set < DLY_MAX) ? DLY_W'(delay_set) : DLY_MAX;
          timeout_seen = (delay_ctr == 0);
        end else if (delay_ctr > 0) begin
          delay_ctr = delay_ctr - 1'b1;
          timeout_seen = (delay_ctr == 0);
        end
        pulse = !was_timed && timeout_seen && keyon_seen;
        keyon_seen_q = keyon_seen;
        g_en = pulse;
        g_act = g_run;
        if (g_run) begin
          if (pulse) begin
            src_side = start_p;
            held_p = PRES_W'(p);
          end else begin
            if (!keyon_seen) held_p = '0;
            src_side = 0;
          end
          diff = (src_side >= held_p) ? src_side - held_p : held_p - src_side;
          g_flt = diff > thr_grad;
          grad_held = (diff < GRD_SAT) ? GRAD_W'(diff) : GRD_SAT;
          lat_held = clip_pressure(held_p);
        end
        old_en = !it.inhibit_old && it.engine_running;
      end
      REQ_KEY_ON: begin
        start_p = clip_pressure(p);
        keyon_seen = 1'b1;
      end
      REQ_INIT: begin
        // gradient enable survives an init
        {r_act, r_hi, r_lo} = '0;
        g_act = 1'b0;
        g_flt = 1'b0;
        old_en = 1'b0;
        start_p = P_MIN;
        ref_old = clip_pressure(int'(it.estimated_ref) * 2 / 25);
      end
      default: ;
    endcase
    s = '{r_act, r_hi, r_lo, g_act, g_en, g_flt, grad_held, lat_held, old_en, ref_old,
          start_p, delay_ctr};
    return s;
  endfunction

  function automatic out_item_t status(bit ra, bit fh, bit fl, bit ga, bit ge, bit fg,
                                       int unsigned gv, int unsigned lat, bit old_c,
                                       int unsigned rf, int unsigned st, int unsigned dly);
    out_item_t s;
    s = '{ra, fh, fl, ga, ge, fg, GRAD_W'(gv), HOLD_W'(lat), old_c, HOLD_W'(rf), HOLD_W'(st),
          DLY_W'(dly)};
    return s;
  endfunction

  function automatic void add_row(logic [1:0] req, int unsigned p, bit eng, bit ir, bit ig,
                                  bit io, int unsigned est, bit typed = 1'b0,
                                  out_item_t want = '0);
    dir_row_t row;
    row.item = '{req, PRES_W'(p), eng, ir, ig, io, EST_W'(est)};
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  task automatic flag_mismatch(string msg);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want) flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin : status_sink
    out_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_status.size() == 0) begin
        flag_mismatch("status transfer with nothing expected");
      end else begin
        want = pending_status.pop_front();
        if ($isunknown(out_if.data)) flag_mismatch("status carries unknown bits");
        check_field("range_active", out_if.data.range_active, want.range_active);
        check_field("fault_high", out_if.data.fault_high, want.fault_high);
        check_field("fault_low", out_if.data.fault_low, want.fault_low);
        check_field("gradient_active", out_if.data.gradient_active, want.gradient_active);
        check_field("gradient_enable", out_if.data.gradient_enable, want.gradient_enable);
        check_field("fault_gradient", out_if.data.fault_gradient, want.fault_gradient);
        check_field("gradient_value", out_if.data.gradient_value, want.gradient_value);
        check_field("latched_pressure", out_if.data.latched_pressure, want.latched_pressure);
        check_field("old_check_active", out_if.data.old_check_active, want.old_check_active);
        check_field("ref_old_pressure", out_if.data.ref_old_pressure, want.ref_old_pressure);
        check_field("start_pressure", out_if.data.start_pressure, want.start_pressure);
        check_field("delay_count", out_if.data.delay_count, want.delay_count);
      end
    end
    out_if.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // entered right after a rising edge; returns at the edge of the transfer
  task automatic feed_item(in_item_t it, bit typed, out_item_t want);
    out_item_t res;
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    res = predict_status(it);
    pending_status.push_back(typed ? want : res);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic put_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_HIGH_THR:   thr_high = val[11:0];
      CFG_LOW_TENS:   thr_low_tens = val[7:0];
      CFG_GRAD_DELAY: delay_set = val;
      CFG_GRAD_THR:   thr_grad = val[11:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [11:0] hi, logic [7:0] lo, logic [15:0] dly,
                               logic [11:0] gthr);
    wait_drained();
    put_reg(CFG_HIGH_THR, CFG_W'(hi));
    put_reg(CFG_LOW_TENS, CFG_W'(lo));
    put_reg(CFG_GRAD_DELAY, dly);
    put_reg(CFG_GRAD_THR, CFG_W'(gthr));
    cfg_we <= 1'b0;
  endtask

  initial begin
    in_item_t it;
    int unsigned pick, r;
    logic [15:0] first_delay;

    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;

    // fresh from reset: values typed in
    add_row(REQ_UNUSED, 4095, 1, 1, 1, 1, 65535, 1,
            status(0, 0, 0, 0, 0, 0, 0, 500, 0, 500, 500, 0));
    add_row(REQ_INIT, 4095, 1, 1, 1, 1, 0, 1,
            status(0, 0, 0, 0, 0, 0, 0, 500, 0, 500, 500, 0));
    add_row(REQ_INIT, 0, 0, 0, 0, 0, 65535, 1,
            status(0, 0, 0, 0, 0, 0, 0, 500, 0, 1500, 500, 0));
    add_row(REQ_TICK, 4095, 1, 0, 1, 0, 0, 1,
            status(1, 1, 0, 0, 0, 0, 0, 500, 1, 1500, 500, 0));
    add_row(REQ_TICK, 0, 0, 0, 0, 1, 0, 1,
            status(1, 0, 1, 0, 0, 0, 0, 500, 0, 1500, 500, 0));
    // range inhibited keeps the low fault, gradient runs before any key-on
    add_row(REQ_TICK, 1000, 1, 1, 0, 1, 0, 1,
            status(0, 0, 1, 1, 0, 0, 0, 500, 0, 1500, 500, 0));
    // repeated key-on stores, clamped both ways
    add_row(REQ_KEY_ON, 4095, 0, 0, 0, 0, 0);
    add_row(REQ_KEY_ON, 0, 1, 1, 1, 1, 65535);
    add_row(REQ_KEY_ON, 900, 1, 0, 0, 0, 0);
    add_row(REQ_TICK, 1101, 1, 0, 0, 0, 0);
    add_row(REQ_TICK, 1100, 1, 0, 0, 0, 0);
    add_row(REQ_TICK, 499, 1, 0, 0, 0, 0);
    add_row(REQ_TICK, 500, 1, 0, 0, 0, 0);
    add_row(REQ_TICK, 2000, 1, 0, 0, 0, 0);
    add_row(REQ_TICK, 600, 0, 0, 0, 0, 0);
    add_row(REQ_INIT, 700, 1, 0, 0, 0, 6249);
    add_row(REQ_INIT, 700, 1, 0, 0, 0, 12500);
    add_row(REQ_TICK, 1300, 1, 0, 1, 0, 0);
    add_row(REQ_UNUSED, 0, 0, 0, 0, 0, 0);
    add_row(REQ_KEY_ON, 1499, 1, 0, 0, 0, 0);
    add_row(REQ_TICK, 700, 1, 0, 0, 0, 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // only one key-on edge per run, so the delay it sees is picked per seed
    pick = $urandom_range(0, 4);
    first_delay = (pick < 2) ? 16'd0 : (pick < 4) ? 16'd2 : 16'hFFFF;
    load_settings(12'd1100, 8'd50, first_delay, 12'd100);
    foreach (dir_rows[k]) feed_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_settings('0, '0, '0, '0);
        1: load_settings('1, '1, '1, '1);
        default: load_settings(12'($urandom_range(600, 1600)), 8'($urandom_range(0, 160)),
                               16'($urandom), 12'($urandom_range(0, 1100)));
      endcase
      quiet <= (ph == 4);
      for (int n = 0; n < 200; n++) begin
        if (ph == 2 && n == 100) wait_drained();
        r = $urandom_range(0, 99);
        it.req_type = (r < 72) ? REQ_TICK : (r < 82) ? REQ_KEY_ON :
                      (r < 92) ? REQ_INIT : REQ_UNUSED;
        case ($urandom_range(0, 9))
          0: it.pressure = '0;
          1: it.pressure = '1;
          2: it.pressure = PRES_W'(thr_high + $urandom_range(0, 2) - 1);
          3: it.pressure = PRES_W'(int'(thr_low_tens) * 10 + $urandom_range(0, 2) - 1);
          4, 5: it.pressure = PRES_W'($urandom_range(400, 1600));
          default: it.pressure = PRES_W'($urandom);
        endcase
        it.engine_running = $urandom_range(0, 9) < 8;
        it.inhibit_range = $urandom_range(0, 4) == 0;
        it.inhibit_gradient = $urandom_range(0, 4) == 0;
        it.inhibit_old = $urandom_range(0, 4) == 0;
        // estimates around the edges of the clamped reference
        case ($urandom_range(0, 5))
          0: it.estimated_ref = '0;
          1: it.estimated_ref = '1;
          2: it.estimated_ref = EST_W'(6249 + $urandom_range(0, 2));
          3: it.estimated_ref = EST_W'(18749 + $urandom_range(0, 2));
          default: it.estimated_ref = EST_W'($urandom);
        endcase
        feed_item(it, 1'b0, '0);
      end
    end

    in_if.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== ambient_pressure_plausibility_monitor.f =====
src/apm_pkg.sv
src/apm_if.sv
src/apm_cfg_regs.sv
src/apm_ref_scale.sv
src/apm_engine.sv
src/ambient_pressure_plausibility_monitor.sv
bench/tb_ambient_pressure_plausibility_monitor.sv
